// ===== src/gph_pkg.sv =====
// Shared types and codes for the ground plane gate with history.
package gph_pkg;

    typedef enum logic [1:0] {
        ST_GIVEN = 2'd0,
        ST_FAIL  = 2'd1,
        ST_RUN   = 2'd2,
        ST_RERUN = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_BLOCK_ENABLE = 3'd0,
        REG_MIN_COUNT    = 3'd1,
        REG_WALL_ENABLE  = 3'd2,
        REG_MAX_RERUNS   = 3'd3,
        REG_WALL_LIMIT   = 3'd4,
        REG_TILT_LIMIT   = 3'd5,
        REG_HEIGHT_LIMIT = 3'd6,
        REG_HEIGHT_OFFS  = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_DSTART,
        S_DIV,
        S_CHECK,
        S_MUL,
        S_OFFS,
        S_OUT
    } state_t;

    typedef enum logic {
        ACT_FRAME = 1'b0,
        ACT_PLANE = 1'b1
    } action_t;

    typedef struct packed {
        logic               action;
        logic [15:0]        point_count;
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [15:0] coef_c;
        logic signed [15:0] coef_d;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               from_history;
        logic signed [15:0] out_a;
        logic signed [15:0] out_b;
        logic signed [15:0] out_c;
        logic signed [15:0] out_d;
    } out_t;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        logic signed [15:0] d;
    } plane_t;

    typedef struct packed {
        logic clr;
        logic acc_en;
        logic div_start;
    } lane_ctl_t;

    localparam int RERUN_MAX = 31;

endpackage

// ===== src/gph_hist.sv =====
// History ring storage: one write port, one registered read port.
module gph_hist
    import gph_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  plane_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output plane_t           rd_data
);

    plane_t mem [DEPTH];
    plane_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/gph_lane.sv =====
// One component lane: sums history words, then divides by the fill count.
module gph_lane
    import gph_pkg::*;
#(
    parameter int FILL_W = 4,
    parameter int SUM_W  = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lane_ctl_t          ctl,
    input  logic signed [15:0] acc_val,
    input  logic [FILL_W-1:0]  divisor,
    output logic signed [15:0] result,
    output logic               done
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0]        quo_reg, quo_next;
    logic [FILL_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    neg_reg, neg_next;
    logic [FILL_W:0]         rem_sh;
    logic [FILL_W:0]         rem_sub;
    logic                    ge;
    logic [SUM_W-1:0]        signed_quo;

    assign rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
    assign ge      = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};
    assign done    = busy_reg && (cnt_reg == '0);
    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign result  = signed_quo[15:0];

    always_comb begin
        sum_next  = sum_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        if (ctl.clr) begin
            sum_next = '0;
        end else if (ctl.acc_en) begin
            sum_next = sum_reg + SUM_W'(acc_val);
        end
        if (ctl.div_start) begin
            // restoring divide on the magnitude, sign applied at the end
            neg_next  = sum_reg[SUM_W-1];
            quo_next  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
            rem_next  = '0;
            cnt_next  = CNT_W'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                rem_next = ge ? rem_sub[FILL_W-1:0] : rem_sh[FILL_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        sum_reg <= sum_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

endmodule

// ===== src/ground_plane_gate_history.sv =====
// Top level of the ground plane gate: control sequencer, lanes and history.
//
// Usage: frame and plane words arrive on the s_ channel (valid/ready); each
// accepted word yields exactly one result word on the m_ channel. A frame
// word answers fail, run-estimator, or the history average; a plane word
// from the estimator answers filter-and-rerun, fail, a checked plane, or the
// history average. Registers are to be written over the APB port only while
// the block is idle; the block itself does not enforce this.
//
// Answer paths: run, fail and rerun answers go from S_IDLE straight to
// S_OUT; a checked plane first passes S_CHECK, S_MUL and S_OFFS. A short
// frame answered from history walks the filled entries one per memory read,
// then four lanes (one per plane component) divide by the fill count one
// quotient bit a cycle, SUM_W = 16 + clog2(HISTORY_DEPTH+1) bits in all. A
// wall fallback adds S_CHECK, and S_MUL and S_OFFS when the average is
// offset and pushed; a plane that fails its checks passes S_CHECK first.
// One word is in flight at a time; s_ready is high only when idle.
//
// Reset clears the sequencer, the rerun count, the ring head and fill and
// the output valid; stored history entries are not cleared. When the
// receiver stalls, hold the result in the output register; the next word
// may already be accepted and computed, but it waits to load until the
// held word is taken.
module ground_plane_gate_history
    import gph_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = 16 + FILL_W;

    // configuration registers
    logic               en_reg;
    logic [15:0]        min_pts_reg;
    logic               wall_en_reg;
    logic [3:0]         max_rr_reg;
    logic [12:0]        wall_lim_reg;
    logic [12:0]        tilt_lim_reg;
    logic [14:0]        height_lim_reg;
    logic signed [15:0] offs_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    // sequencer state
    state_t             state_reg, state_next;
    plane_t             p_reg, p_next;
    logic               hist_reg, hist_next;
    logic               plain_reg, plain_next;
    logic [4:0]         rerun_reg, rerun_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rd_vld_reg, rd_vld_next;
    logic signed [31:0] prod_reg, prod_next;
    out_t               res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    // datapath helpers
    plane_t             flip;
    logic [16:0]        mag_flip_c;
    logic [16:0]        mag_c;
    logic [16:0]        mag_d;
    logic               ground_ok;
    logic [4:0]         rr_inc;
    logic signed [19:0] quot;
    logic signed [20:0] new_d;
    logic signed [15:0] d_sat;
    logic               mem_wr;
    plane_t             rd_data;
    plane_t             avg;
    lane_ctl_t          lane_ctl;
    logic [3:0]         lane_done;
    logic signed [15:0] lane_in  [4];
    logic signed [15:0] lane_out [4];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_comb begin
        case (cfg_idx)
            REG_BLOCK_ENABLE: prdata = {31'd0, en_reg};
            REG_MIN_COUNT:    prdata = {16'd0, min_pts_reg};
            REG_WALL_ENABLE:  prdata = {31'd0, wall_en_reg};
            REG_MAX_RERUNS:   prdata = {28'd0, max_rr_reg};
            REG_WALL_LIMIT:   prdata = {19'd0, wall_lim_reg};
            REG_TILT_LIMIT:   prdata = {19'd0, tilt_lim_reg};
            REG_HEIGHT_LIMIT: prdata = {17'd0, height_lim_reg};
            REG_HEIGHT_OFFS:  prdata = {{16{offs_reg[15]}}, offs_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg         <= 1'b1;
            min_pts_reg    <= 16'd50;
            wall_en_reg    <= 1'b1;
            max_rr_reg     <= 4'd3;
            wall_lim_reg   <= 13'd819;
            tilt_lim_reg   <= 13'd4034;
            height_lim_reg <= 15'd819;
            offs_reg       <= 16'sd410;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BLOCK_ENABLE: en_reg         <= pwdata[0];
                REG_MIN_COUNT:    min_pts_reg    <= pwdata[15:0];
                REG_WALL_ENABLE:  wall_en_reg    <= pwdata[0];
                REG_MAX_RERUNS:   max_rr_reg     <= pwdata[3:0];
                REG_WALL_LIMIT:   wall_lim_reg   <= pwdata[12:0];
                REG_TILT_LIMIT:   tilt_lim_reg   <= pwdata[12:0];
                REG_HEIGHT_LIMIT: height_lim_reg <= pwdata[14:0];
                REG_HEIGHT_OFFS:  offs_reg       <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // ---------------- history ring and component lanes ----------------
    gph_hist #(
        .DEPTH (HISTORY_DEPTH),
        .IDX_W (IDX_W)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .wr_addr (head_reg),
        .wr_data ({p_reg.a, p_reg.b, p_reg.c, d_sat}),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign lane_in[0] = rd_data.a;
    assign lane_in[1] = rd_data.b;
    assign lane_in[2] = rd_data.c;
    assign lane_in[3] = rd_data.d;

    assign lane_ctl.clr       = (state_reg == S_IDLE);
    assign lane_ctl.acc_en    = rd_vld_reg;
    assign lane_ctl.div_start = (state_reg == S_DSTART);

    for (genvar g = 0; g < 4; g++) begin : g_lane
        gph_lane #(
            .FILL_W (FILL_W),
            .SUM_W  (SUM_W)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .acc_val (lane_in[g]),
            .divisor (fill_reg),
            .result  (lane_out[g]),
            .done    (lane_done[g])
        );
    end

    // merge the lane quotients back into one plane
    assign avg = {lane_out[0], lane_out[1], lane_out[2], lane_out[3]};

    // ---------------- merge-side datapath ----------------
    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        neg_sat = (v == -16'sd32768) ? 16'sd32767 : -v;
    endfunction

    function automatic logic [16:0] mag17(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = 17'(v);
        mag17 = v[15] ? 17'(-w) : 17'(w);
    endfunction

    // flip so the normal points up
    always_comb begin
        if (s_data.coef_c[15]) begin
            flip = {neg_sat(s_data.coef_a), neg_sat(s_data.coef_b),
                    neg_sat(s_data.coef_c), neg_sat(s_data.coef_d)};
        end else begin
            flip = {s_data.coef_a, s_data.coef_b, s_data.coef_c, s_data.coef_d};
        end
    end

    assign mag_flip_c = mag17(flip.c);
    assign mag_c      = mag17(p_reg.c);
    assign mag_d      = mag17(p_reg.d);
    assign ground_ok  = (mag_c >= {4'd0, tilt_lim_reg}) && (mag_d <= {2'd0, height_lim_reg});
    assign rr_inc     = (rerun_reg < 5'(RERUN_MAX)) ? rerun_reg + 5'd1 : rerun_reg;

    // c*offset over 4096, truncated toward zero, then taken from d
    assign quot  = 20'((prod_reg + (prod_reg[31] ? 32'sd4095 : 32'sd0)) >>> 12);
    assign new_d = 21'(p_reg.d) - 21'(quot);
    assign d_sat = (new_d > 21'sd32767)  ? 16'sd32767 :
                   (new_d < -21'sd32768) ? -16'sd32768 : new_d[15:0];

    // ---------------- sequencer ----------------
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        p_next       = p_reg;
        hist_next    = hist_reg;
        plain_next   = plain_reg;
        rerun_next   = rerun_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        rd_idx_next  = rd_idx_reg;
        rd_vld_next  = 1'b0;
        prod_next    = prod_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_wr       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_next   = '0;
                    hist_next  = 1'b0;
                    rd_idx_next = '0;
                    state_next = S_OUT;
                    if (s_data.action == ACT_FRAME) begin
                        rerun_next = '0;
                        if (!en_reg) begin
                            res_next.status = ST_FAIL;
                        end else if (s_data.point_count < min_pts_reg) begin
                            if (fill_reg == '0) begin
                                res_next.status = ST_FAIL;
                            end else begin
                                plain_next = 1'b1;
                                state_next = S_READ;
                            end
                        end else begin
                            res_next.status = ST_RUN;
                        end
                    end else begin
                        p_next = flip;
                        if (wall_en_reg && (mag_flip_c < {4'd0, wall_lim_reg})) begin
                            if (rr_inc <= {1'b0, max_rr_reg}) begin
                                rerun_next      = rr_inc;
                                res_next.status = ST_RERUN;
                            end else begin
                                rerun_next = '0;
                                if (fill_reg == '0) begin
                                    res_next.status = ST_FAIL;
                                end else begin
                                    plain_next = 1'b0;
                                    state_next = S_READ;
                                end
                            end
                        end else begin
                            rerun_next = '0;
                            state_next = S_CHECK;
                        end
                    end
                end
            end
            S_READ: begin
                // stream filled entries into the lanes, one per cycle
                rd_vld_next = 1'b1;
                if (FILL_W'(rd_idx_reg) == fill_reg - 1'b1) begin
                    state_next = S_DRAIN;
                end else begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                state_next = S_DSTART;
            end
            S_DSTART: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (lane_done[0]) begin
                    if (plain_reg) begin
                        res_next = {ST_GIVEN, 1'b1, avg.a, avg.b, avg.c, avg.d};
                        state_next = S_OUT;
                    end else begin
                        p_next     = avg;
                        hist_next  = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (ground_ok) begin
                    state_next = S_MUL;
                end else if (hist_reg) begin
                    // p already holds the unchanged average
                    res_next = {ST_GIVEN, 1'b1, p_reg.a, p_reg.b, p_reg.c, p_reg.d};
                    state_next = S_OUT;
                end else if (fill_reg == '0) begin
                    res_next        = '0;
                    res_next.status = ST_FAIL;
                    state_next      = S_OUT;
                end else begin
                    plain_next  = 1'b1;
                    rd_idx_next = '0;
                    state_next  = S_READ;
                end
            end
            S_MUL: begin
                prod_next  = 32'(p_reg.c) * 32'(offs_reg);
                state_next = S_OFFS;
            end
            S_OFFS: begin
                // push the offset plane and advance the ring
                mem_wr    = 1'b1;
                head_next = (head_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                if (fill_reg != FILL_W'(HISTORY_DEPTH)) begin
                    fill_next = fill_reg + 1'b1;
                end
                res_next = {ST_GIVEN, hist_reg, p_reg.a, p_reg.b, p_reg.c, d_sat};
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rerun_reg   <= '0;
            head_reg    <= '0;
            fill_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rerun_reg   <= rerun_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
        p_reg      <= p_next;
        hist_reg   <= hist_next;
        plain_reg  <= plain_next;
        rd_idx_reg <= rd_idx_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== src/gph_check.sv =====
// Port-level checker for the ground plane gate, bound to the top level.
module gph_check
    import gph_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // only a given plane carries plane fields
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_GIVEN) |->
            !m_data.from_history && (m_data.out_a == 16'sd0) &&
            (m_data.out_b == 16'sd0) && (m_data.out_c == 16'sd0) &&
            (m_data.out_d == 16'sd0))
        else $error("non-plane result carries data");

    // every given plane has its normal flipped upward
    a_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_GIVEN) |-> !m_data.out_c[15])
        else $error("given plane points down");

    // nothing leaves right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ground_plane_gate_history gph_check u_gph_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the ground plane gate with history.
`timescale 1ns / 100ps

module tb_top;
    import gph_pkg::*;

    localparam int DEPTH = 8;
    localparam int LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ground_plane_gate_history #(.HISTORY_DEPTH(DEPTH)) u_dut (.*);

    // Predictor copy of the configuration.
    logic        gate_en;
    logic [15:0] count_floor;
    logic        wall_en;
    logic [3:0]  rerun_budget;
    int          wall_lim;
    int          tilt_lim;
    int          height_lim;
    int          height_offs;

    // Predictor copy of the state.
    int ring [DEPTH][4];
    int ring_head;
    int ring_fill;
    int reruns;

    out_t expected_words[$];
    int   errors;
    int   cycles;
    int   idle_pct;      // chance of a gap per cycle, both sides
    bit   hold_sink;     // receiver holds off while set

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("ground_plane_gate_history regression: fail");
            $finish;
        end
    end

    function automatic int sat_word(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int magnitude(int v);
        return v < 0 ? -v : v;
    endfunction

    // Average the ring, truncating toward zero; zero when empty.
    function automatic bit ring_average(output int p[4]);
        int sum[4];
        for (int k = 0; k < 4; k++) sum[k] = 0;
        for (int k = 0; k < 4; k++) p[k] = 0;
        if (ring_fill == 0) return 0;
        for (int i = 0; i < ring_fill; i++)
            for (int k = 0; k < 4; k++) sum[k] += ring[i][k];
        for (int k = 0; k < 4; k++) p[k] = sum[k] / ring_fill;
        return 1;
    endfunction

    function automatic out_t make_word(status_t st, bit hist, int p[4]);
        out_t w;
        w.status       = st;
        w.from_history = hist;
        w.out_a        = p[0][15:0];
        w.out_b        = p[1][15:0];
        w.out_c        = p[2][15:0];
        w.out_d        = p[3][15:0];
        return w;
    endfunction

    // Compute the answer to one word and advance the predicted state.
    function automatic out_t gate_predict(in_t w);
        int  p[4];
        int  zero[4];
        int  q;
        bit  hist;
        hist = 0;
        for (int k = 0; k < 4; k++) zero[k] = 0;
        if (w.action == ACT_FRAME) begin
            reruns = 0;
            if (!gate_en) return make_word(ST_FAIL, 0, zero);
            if (w.point_count < count_floor) begin
                if (!ring_average(p)) return make_word(ST_FAIL, 0, zero);
                return make_word(ST_GIVEN, 1, p);
            end
            return make_word(ST_RUN, 0, zero);
        end
        p[0] = w.coef_a;
        p[1] = w.coef_b;
        p[2] = w.coef_c;
        p[3] = w.coef_d;
        if (p[2] < 0)
            for (int k = 0; k < 4; k++) p[k] = sat_word(-p[k]);
        if (wall_en && magnitude(p[2]) < wall_lim) begin
            if (reruns < RERUN_MAX) reruns++;
            if (reruns <= rerun_budget) return make_word(ST_RERUN, 0, zero);
            reruns = 0;
            if (!ring_average(p)) return make_word(ST_FAIL, 0, zero);
            hist = 1;
        end
        reruns = 0;
        if (magnitude(p[2]) >= tilt_lim && magnitude(p[3]) <= height_lim) begin
            q = (p[2] * height_offs) / 4096;
            p[3] = sat_word(p[3] - q);
            for (int k = 0; k < 4; k++) ring[ring_head][k] = p[k];
            ring_head = (ring_head + 1) % DEPTH;
            if (ring_fill < DEPTH) ring_fill++;
            return make_word(ST_GIVEN, hist, p);
        end
        if (!ring_average(p)) return make_word(ST_FAIL, 0, zero);
        return make_word(ST_GIVEN, 1, p);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Receiver: random stalls, plus a long hold while hold_sink is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_sink && ($urandom_range(99) >= idle_pct);
        end
    end

    // Check each accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected result word", 1, 0);
            end else begin
                want = expected_words[0];
                expected_words.delete(0);
                if (m_data.status != want.status)
                    report_mismatch("status", m_data.status, want.status);
                if (m_data.from_history != want.from_history)
                    report_mismatch("from_history", m_data.from_history,
                                    want.from_history);
                if (m_data.out_a != want.out_a)
                    report_mismatch("out_a", m_data.out_a, want.out_a);
                if (m_data.out_b != want.out_b)
                    report_mismatch("out_b", m_data.out_b, want.out_b);
                if (m_data.out_c != want.out_c)
                    report_mismatch("out_c", m_data.out_c, want.out_c);
                if (m_data.out_d != want.out_d)
                    report_mismatch("out_d", m_data.out_d, want.out_d);
            end
        end
    end

    // Offer one word, hold it until accepted, predict its answer.
    // Valid drops only when a gap follows; drain drops it at the end.
    task automatic send_word(in_t w);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.insert(expected_words.size(), gate_predict(w));
    endtask

    task automatic send_frame(int count);
        in_t w;
        w = '0;
        w.action      = ACT_FRAME;
        w.point_count = count[15:0];
        w.coef_a      = $urandom;
        w.coef_d      = $urandom;
        send_word(w);
    endtask

    task automatic send_plane(int a, int b, int c, int d);
        in_t w;
        w.action      = ACT_PLANE;
        w.point_count = $urandom;
        w.coef_a      = a[15:0];
        w.coef_b      = b[15:0];
        w.coef_c      = c[15:0];
        w.coef_d      = d[15:0];
        send_word(w);
    endtask

    // Wait out every answer, then the block's longest latency.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_BLOCK_ENABLE: gate_en      = value[0];
            REG_MIN_COUNT:    count_floor  = value[15:0];
            REG_WALL_ENABLE:  wall_en      = value[0];
            REG_MAX_RERUNS:   rerun_budget = value[3:0];
            REG_WALL_LIMIT:   wall_lim     = value[12:0];
            REG_TILT_LIMIT:   tilt_lim     = value[12:0];
            REG_HEIGHT_LIMIT: height_lim   = value[14:0];
            REG_HEIGHT_OFFS:  height_offs  = $signed(value[15:0]);
            default: ;
        endcase
    endtask

    task automatic set_config(int en, int minp, int wen, int mr, int wl,
                              int tl, int hl, int ho);
        write_reg(REG_BLOCK_ENABLE, en);
        write_reg(REG_MIN_COUNT, minp);
        write_reg(REG_WALL_ENABLE, wen);
        write_reg(REG_MAX_RERUNS, mr);
        write_reg(REG_WALL_LIMIT, wl);
        write_reg(REG_TILT_LIMIT, tl);
        write_reg(REG_HEIGHT_LIMIT, hl);
        write_reg(REG_HEIGHT_OFFS, ho);
    endtask

    // Random plane: just over half are ground-like, with c near the tilt limit.
    task automatic send_random_plane();
        int pick;
        int c;
        pick = $urandom_range(99);
        if (pick < 55) c = $urandom_range(4096, 3800);
        else if (pick < 75) c = $urandom_range(900, 0);
        else c = $signed(16'($urandom));
        if ($urandom_range(1)) c = -c;
        if (pick < 55)
            send_plane($signed(12'($urandom)), $signed(12'($urandom)), c,
                       $signed(11'($urandom)));
        else
            send_plane($signed(16'($urandom)), $signed(16'($urandom)), c,
                       $signed(16'($urandom)));
    endtask

    // Directed: empty history, extremes, flips, reruns, fallbacks.
    task automatic test_directed();
        send_frame(0);                        // no history: fail
        send_plane(0, 0, 100, 0);             // wall, rerun 1
        send_plane(0, 0, 100, 0);
        send_plane(0, 0, 100, 0);
        send_plane(0, 0, 100, 0);             // budget spent, no history: fail
        send_plane(0, 0, 4096, 900);          // tilt ok, height too big: fail
        send_plane(10, -20, 4096, 300);       // accepted, pushed
        send_plane(-32768, 32767, -4096, -32768); // flip with saturation
        send_plane(32767, -32768, -32768, 32767); // flip, c saturates
        send_frame(49);                       // history average
        send_frame(50);                       // run estimator
        send_frame(65535);
        send_plane(0, 0, 0, 0);               // wall then rerun
        send_plane(5, 5, 4000, 100);          // bad tilt: average fallback
        for (int i = 0; i < 4; i++) send_plane(0, 0, -10, 0);
        send_plane(0, 0, 4090, -819);
        send_plane(1, 2, 32767, 819);
        drain();
    endtask

    task automatic test_config_extremes();
        set_config(0, 50, 1, 3, 819, 4034, 819, 410);
        send_frame(65535);
        send_frame(0);
        send_plane(0, 0, 4096, 0);
        drain();
        set_config(1, 65535, 0, 0, 0, 0, 32767, -32768);
        send_frame(65534);
        send_plane(100, 200, -32768, -32768);
        send_plane(-5, 7, 32767, 32767);
        send_frame(65535);
        drain();
        set_config(1, 0, 1, 0, 4096, 4096, 0, 32767);
        send_plane(0, 0, 4095, 0);
        send_plane(0, 0, 4096, 0);
        send_frame(0);
        drain();
        set_config(1, 50, 1, 15, 8191, 0, 32767, 410);
        for (int i = 0; i < 17; i++) send_plane(1, 1, 1, 1);
        drain();
    endtask

    // Random mix of frames of any count, short frames and planes; broken sequences too.
    task automatic random_run(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 30) send_frame($urandom_range(65535));
            else if ($urandom_range(99) < 10) send_frame($urandom_range(60));
            else send_random_plane();
        end
    endtask

    task automatic test_random();
        set_config(1, 50, 1, 3, 819, 4034, 819, 410);
        random_run(250);
        drain();
        set_config(1, $urandom_range(200), 1, $urandom_range(15),
                   $urandom_range(2000), $urandom_range(4096, 3000),
                   $urandom_range(32767), $signed(16'($urandom)));
        random_run(250);
        drain();
    endtask

    // Receiver holds off while the sender keeps offering.
    task automatic test_backpressure();
        idle_pct = 0;
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(posedge aclk);
                hold_sink = 1'b0;
            end
            random_run(60);
        join
        drain();
        idle_pct = 37;
    endtask

    // Stretch with no idling at all, then sender pauses for a full drain; an idling run follows.
    task automatic test_no_idle();
        idle_pct = 0;
        random_run(150);
        drain();
        idle_pct = 37;
        random_run(50);
        drain();
    endtask

    initial begin
        errors    = 0;
        cycles    = 0;
        idle_pct  = 37;
        hold_sink = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        gate_en = 1; count_floor = 50; wall_en = 1; rerun_budget = 3;
        wall_lim = 819; tilt_lim = 4034; height_lim = 819; height_offs = 410;
        ring_head = 0; ring_fill = 0; reruns = 0;
        for (int i = 0; i < DEPTH; i++)
            for (int k = 0; k < 4; k++) ring[i][k] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_extremes();
        test_random();
        test_backpressure();
        test_no_idle();
        if (errors == 0 && expected_words.size() == 0) begin
            $display("ground_plane_gate_history regression: pass");
        end else begin
            $display("ground_plane_gate_history regression: fail");
        end
        $finish;
    end

endmodule
